// ----- rtl/crrf_pkg.sv -----
// package for the challenge-response report framer
// shared types, codes and constants; no dependencies
package crrf_pkg;

  localparam logic [2:0] MODE_SET     = 3'd0;
  localparam logic [2:0] MODE_GET     = 3'd1;
  localparam logic [2:0] MODE_DIGEST  = 3'd2;
  localparam logic [2:0] MODE_CONFIRM = 3'd3;
  localparam logic [2:0] MODE_CANCEL  = 3'd4;
  localparam logic [2:0] MODE_FAIL    = 3'd5;
  localparam logic [2:0] MODE_SPARE6  = 3'd6;
  localparam logic [2:0] MODE_SPARE7  = 3'd7;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PENDING = 2'd1;
  localparam logic [1:0] PH_WAITING = 2'd2;
  localparam logic [1:0] PH_READY   = 2'd3;

  localparam int FRAME_LEN  = 70;
  localparam int FRAME_ROWS = 10;
  localparam int RESP_LEN   = 22;
  localparam int DIGEST_LEN = 20;
  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [2:0] REG_MAJOR = 3'd0;
  localparam logic [2:0] REG_MINOR = 3'd1;
  localparam logic [2:0] REG_BUILD = 3'd2;
  localparam logic [2:0] REG_TOUCH = 3'd3;
  localparam logic [2:0] REG_SLOT  = 3'd4;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
    logic [15:0] init;
  } crc_req_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CRC   = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_EMIT  = 6'b001000,
    ST_OUT   = 6'b010000,
    ST_DIG   = 6'b100000
  } state_t;

endpackage

// ----- rtl/crrf_crc_unit.sv -----
// bit-serial crc16 unit, reflected poly 0x8408, one bit per cycle
// depends on crrf_pkg
module crrf_crc_unit (
  input  logic              clk,
  input  logic              rst,
  input  crrf_pkg::crc_req_t req,
  output logic              busy,
  output logic [15:0]       crc
);
  logic [2:0] cnt;
  logic [15:0] s;
  always_comb s = req.init ^ {8'h00, req.data};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= '0;
      crc  <= s;
    end else if (busy) begin
      crc <= (crc >> 1) ^ (crc[0] ? crrf_pkg::CRC_POLY : 16'h0000);
      cnt <= cnt + 3'd1;
      if (cnt == 3'd7) busy <= 1'b0;
    end
  end
endmodule

// ----- rtl/challenge_response_report_framer_unit.sv -----
// top level of the challenge-response report framer
// depends on crrf_pkg and crrf_crc_unit
//
// usage: input beats on s_tvalid/s_tready/s_tdata carry one event each
// (set report, get report, digest byte, confirm, cancel, compute failed).
// results leave on m_tvalid/m_tready/m_tdata with m_tuser = kind and
// m_tlast closing each event's run. a get report gives one reply beat.
// a set report of the last block runs a crc over the 64 stored payload
// bytes through one bit-serial crc unit, one byte after another, then a
// check state compares the crc and the slot byte, and on a match the 8
// challenge words go out, each through an emit and an out state.
// a digest byte in the pending phase goes through the same crc unit; a
// get report and the other events are handled in the idle state.
// s_tready is low while an event is in work or a result waits; a stalled
// receiver holds the block with the result in place.
// reset clears phase, counters and both stores; registers take their
// reset values. the frame store is also cleared on block zero and on
// reports without the write flag.
module challenge_response_report_framer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,  // mode[2:0], report_data[58:3], report_flag[66:59],
                                // digest_byte[74:67], touch_required[75], zero fill
  input  logic        m_tready,
  output logic        m_tvalid,
  output logic [63:0] m_tdata,  // payload
  output logic        m_tuser,  // kind
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [7:0] version_major, version_minor, version_build, accepted_slot;
  logic [15:0] status_touch_level;
  logic [2:0] ridx;
  assign pready = 1'b1;
  assign ridx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      version_major <= 8'd2;
      version_minor <= 8'd4;
      version_build <= 8'd0;
      status_touch_level <= 16'd11;
      accepted_slot <= 8'h38;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        crrf_pkg::REG_MAJOR: version_major <= pwdata[7:0];
        crrf_pkg::REG_MINOR: version_minor <= pwdata[7:0];
        crrf_pkg::REG_BUILD: version_build <= pwdata[7:0];
        crrf_pkg::REG_TOUCH: status_touch_level <= pwdata[15:0];
        crrf_pkg::REG_SLOT:  accepted_slot <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      crrf_pkg::REG_MAJOR: prdata = {24'd0, version_major};
      crrf_pkg::REG_MINOR: prdata = {24'd0, version_minor};
      crrf_pkg::REG_BUILD: prdata = {24'd0, version_build};
      crrf_pkg::REG_TOUCH: prdata = {16'd0, status_touch_level};
      crrf_pkg::REG_SLOT:  prdata = {24'd0, accepted_slot};
      default:             prdata = '0;
    endcase
  end

  // input fields
  logic [2:0]  in_mode;
  logic [55:0] in_data;
  logic [7:0]  in_flag, in_db;
  logic        in_touch;
  assign in_mode  = s_tdata[2:0];
  assign in_data  = s_tdata[58:3];
  assign in_flag  = s_tdata[66:59];
  assign in_db    = s_tdata[74:67];
  assign in_touch = s_tdata[75];

  // stores: frame rows of seven bytes, response bytes with valid bits
  logic [55:0] frame [crrf_pkg::FRAME_ROWS];
  logic [8*crrf_pkg::FRAME_LEN-1:0] flat;
  logic [7:0] resp [crrf_pkg::RESP_LEN];
  logic [crrf_pkg::RESP_LEN-1:0] rvalid;

  always_comb begin
    for (int r = 0; r < crrf_pkg::FRAME_ROWS; r++) flat[56*r +: 56] = frame[r];
  end

  logic [1:0]  phase;
  logic [2:0]  read_index;
  logic [4:0]  digest_count;
  logic [15:0] digest_crc;
  logic        touch_hold;

  crrf_pkg::state_t state;
  logic [5:0]  bidx;
  logic [2:0]  word;
  logic [15:0] crc_acc;
  logic        crc_started;

  crrf_pkg::crc_req_t creq;
  logic        cbusy;
  logic [15:0] cval;
  crrf_crc_unit u_crc (.clk(clk), .rst(rst), .req(creq), .busy(cbusy), .crc(cval));

  logic in_go;
  assign s_tready = (state == crrf_pkg::ST_IDLE) && !m_tvalid;
  assign in_go = s_tvalid && s_tready;

  function automatic logic [7:0] fbyte(input logic [7:0] v, input logic ok);
    return ok ? v : 8'h00;
  endfunction

  logic [6:0] seq;
  assign seq = in_flag[6:0];

  logic [7:0] crc_byte_in;
  assign crc_byte_in = flat[{bidx, 3'b000} +: 8];

  always_comb begin
    creq.start = 1'b0;
    creq.data  = crc_byte_in;
    creq.init  = crc_acc;
    if (in_go && in_mode == crrf_pkg::MODE_DIGEST && phase == crrf_pkg::PH_PENDING &&
        digest_count < 5'(crrf_pkg::DIGEST_LEN)) begin
      creq.start = 1'b1;
      creq.data  = in_db;
      creq.init  = digest_crc;
    end
    if (state == crrf_pkg::ST_CRC && !cbusy && !crc_started) creq.start = 1'b1;
  end

  logic [15:0] sent;
  logic [7:0]  slot_byte;
  assign sent = flat[8*65 +: 16];
  assign slot_byte = flat[8*64 +: 8];

  logic [63:0] word_data;
  assign word_data = flat[{word, 6'd0} +: 64];

  logic [63:0] get_p;
  logic [4:0]  roff;
  assign roff = 5'(read_index * 5'd7);
  always_comb begin
    get_p = '0;
    for (int i = 0; i < 7; i++) begin
      if (32'(roff) + i < crrf_pkg::RESP_LEN)
        get_p[8*i +: 8] = fbyte(resp[5'(32'(roff) + i)], rvalid[5'(32'(roff) + i)]);
    end
    get_p[63:56] = 8'h40 | {5'd0, read_index + 3'd1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crrf_pkg::ST_IDLE;
      for (int r = 0; r < crrf_pkg::FRAME_ROWS; r++) frame[r] <= '0;
      rvalid <= '0;
      phase <= crrf_pkg::PH_IDLE;
      read_index <= '0;
      digest_count <= '0;
      digest_crc <= crrf_pkg::CRC_INIT;
      m_tvalid <= 1'b0;
      crc_started <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        crrf_pkg::ST_IDLE: begin
          if (in_go) begin
            case (in_mode)
              crrf_pkg::MODE_SET: begin
                if (!in_flag[7]) begin
                  for (int r = 0; r < crrf_pkg::FRAME_ROWS; r++) frame[r] <= '0;
                  rvalid <= '0;
                  phase <= crrf_pkg::PH_IDLE;
                  read_index <= '0;
                  digest_count <= '0;
                  digest_crc <= crrf_pkg::CRC_INIT;
                end else if (seq < 7'd10) begin
                  if (seq == 7'd0) begin
                    for (int r = 1; r < crrf_pkg::FRAME_ROWS; r++) frame[r] <= '0;
                    if (phase != crrf_pkg::PH_IDLE) begin
                      phase <= crrf_pkg::PH_IDLE;
                      read_index <= '0;
                    end
                  end
                  frame[seq[3:0]] <= in_data;
                  if (seq == 7'd9) begin
                    state <= crrf_pkg::ST_CRC;
                    bidx <= '0;
                    crc_acc <= crrf_pkg::CRC_INIT;
                    crc_started <= 1'b0;
                  end
                end
              end
              crrf_pkg::MODE_GET: begin
                m_tvalid <= 1'b1;
                m_tuser  <= 1'b0;
                m_tlast  <= 1'b1;
                unique case (phase)
                  crrf_pkg::PH_PENDING, crrf_pkg::PH_WAITING:
                    m_tdata <= {8'h40, 56'd0};
                  crrf_pkg::PH_READY: begin
                    if (read_index > 3'd3) begin
                      m_tdata <= '0;
                      phase <= crrf_pkg::PH_IDLE;
                      read_index <= '0;
                    end else begin
                      m_tdata <= get_p;
                      read_index <= read_index + 3'd1;
                    end
                  end
                  default:
                    m_tdata <= {16'd0, status_touch_level, 8'h01, version_build,
                                version_minor, version_major};
                endcase
              end
              crrf_pkg::MODE_DIGEST: begin
                if (phase == crrf_pkg::PH_PENDING &&
                    digest_count < 5'(crrf_pkg::DIGEST_LEN)) begin
                  resp[digest_count] <= in_db;
                  rvalid[digest_count] <= 1'b1;
                  digest_count <= digest_count + 5'd1;
                  touch_hold <= in_touch;
                  state <= crrf_pkg::ST_DIG;
                end
              end
              crrf_pkg::MODE_CONFIRM: begin
                if (phase == crrf_pkg::PH_WAITING) begin
                  read_index <= '0;
                  phase <= crrf_pkg::PH_READY;
                end
              end
              crrf_pkg::MODE_CANCEL: begin
                phase <= crrf_pkg::PH_IDLE;
                read_index <= '0;
              end
              crrf_pkg::MODE_FAIL: begin
                if (phase == crrf_pkg::PH_PENDING) phase <= crrf_pkg::PH_IDLE;
              end
              default: ;
            endcase
          end
        end
        crrf_pkg::ST_DIG: begin
          if (!cbusy) begin
            digest_crc <= cval;
            state <= crrf_pkg::ST_IDLE;
            if (digest_count == 5'(crrf_pkg::DIGEST_LEN)) begin
              resp[20] <= ~cval[7:0];
              resp[21] <= ~cval[15:8];
              rvalid[20] <= 1'b1;
              rvalid[21] <= 1'b1;
              read_index <= '0;
              phase <= touch_hold ? crrf_pkg::PH_WAITING : crrf_pkg::PH_READY;
            end
          end
        end
        crrf_pkg::ST_CRC: begin
          // the unit starts when idle and not started; collect after it goes idle
          if (!cbusy) begin
            if (crc_started) begin
              crc_acc <= cval;
              crc_started <= 1'b0;
              if (bidx == 6'd63) state <= crrf_pkg::ST_CHECK;
              else bidx <= bidx + 6'd1;
            end else begin
              crc_started <= 1'b1;
            end
          end
        end
        crrf_pkg::ST_CHECK: begin
          if (crc_acc != sent || slot_byte != accepted_slot) begin
            phase <= crrf_pkg::PH_IDLE;
            state <= crrf_pkg::ST_IDLE;
          end else begin
            phase <= crrf_pkg::PH_PENDING;
            digest_count <= '0;
            digest_crc <= crrf_pkg::CRC_INIT;
            word <= '0;
            state <= crrf_pkg::ST_EMIT;
          end
        end
        crrf_pkg::ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser <= 1'b1;
            m_tdata <= word_data;
            m_tlast <= (word == 3'd7);
            state <= crrf_pkg::ST_OUT;
          end
        end
        crrf_pkg::ST_OUT: begin
          if (m_tready) begin
            if (m_tlast) state <= crrf_pkg::ST_IDLE;
            else begin
              word <= word + 3'd1;
              state <= crrf_pkg::ST_EMIT;
            end
          end
        end
        default: state <= crrf_pkg::ST_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != crrf_pkg::ST_IDLE) |-> !s_tready)
    else $error("input taken while busy");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    digest_count <= 5'(crrf_pkg::DIGEST_LEN))
    else $error("digest count overflow");
  a_emit_kind: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && state == crrf_pkg::ST_OUT) |-> m_tuser)
    else $error("challenge word with wrong kind");
endmodule
